// ----- src/bcd_rtc_pkg.sv -----
// Shared widths, masks, status codes and helpers for the BCD clock register decoder.
// No dependencies.
`default_nettype none

package bcd_rtc_pkg;

    localparam int STATUS_W  = 2;
    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DAY   = 2'd2;

    localparam logic [YEAR_W-1:0] YEAR_BASE = 12'd2000;

    localparam logic [7:0] SEC_MASK   = 8'h7F;
    localparam logic [7:0] DATE_MASK  = 8'h3F;
    localparam logic [7:0] MONTH_MASK = 8'h1F;
    localparam logic [7:0] H12_MASK   = 8'h1F;
    localparam logic [7:0] H24_MASK   = 8'h3F;
    localparam int         H12_BIT    = 6;
    localparam int         PM_BIT     = 5;

    // Both nibbles must be decimal digits
    function automatic logic digits_ok(input logic [7:0] v);
        digits_ok = (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
    endfunction

    // tens * 10 + ones, as tens*8 + tens*2 + ones
    function automatic logic [6:0] bcd_value(input logic [7:0] v);
        bcd_value = {v[7:4], 3'b000} + {2'b00, v[7:4], 1'b0} + {3'b000, v[3:0]};
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        d = 5'd0;
        unique case (m)
            4'd2:                       d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:         d = 5'd31;
            default:                    d = 5'd0;
        endcase
        month_days = d;
    endfunction

endpackage

`default_nettype wire

// ----- src/bcd_rtc_time_decode_validate_top.sv -----
// BCD clock register decoder: three-stage pipeline from raw register bytes to binary date/time.
// Depends on bcd_rtc_pkg.
`default_nettype none

// Decodes one snapshot of six raw clock register bytes (seconds, minutes, hours, date,
// month, year) into binary date and time with a status code: 0 ok, 1 bad BCD digit or
// field out of range, 2 day outside the month. All date/time outputs are zero when the
// status is not ok. A snapshot is taken on every cycle in which start is high; busy is
// never raised, so a new snapshot may follow in every cycle. Each result passes the three
// register stages (digit check and BCD conversion, range check and month length, day check
// and year offset) and appears on o_valid for one cycle only, and must be captured then:
// there is no way to hold it.
module bcd_rtc_time_decode_validate_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  [7:0]                            i_seconds_raw,
    input  wire  [7:0]                            i_minutes_raw,
    input  wire  [7:0]                            i_hours_raw,
    input  wire  [7:0]                            i_date_raw,
    input  wire  [7:0]                            i_month_raw,
    input  wire  [7:0]                            i_year_raw,
    output logic                                  o_valid,
    output logic [bcd_rtc_pkg::STATUS_W-1:0]      o_status,
    output logic [bcd_rtc_pkg::YEAR_W-1:0]        o_year,
    output logic [bcd_rtc_pkg::MONTH_W-1:0]       o_month,
    output logic [bcd_rtc_pkg::DAY_W-1:0]         o_day,
    output logic [bcd_rtc_pkg::HOUR_W-1:0]        o_hour,
    output logic [bcd_rtc_pkg::MINUTE_W-1:0]      o_minute,
    output logic [bcd_rtc_pkg::SECOND_W-1:0]      o_second
);
    import bcd_rtc_pkg::*;

    typedef struct packed {
        logic       digits_ok;
        logic       mode12;
        logic       pm;
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hour;
        logic [5:0] date;
        logic [4:0] mon;
        logic [6:0] yr;
    } t_s1;

    typedef struct packed {
        logic       range_err;
        logic [4:0] hour;
        logic [5:0] sec;
        logic [5:0] min;
        logic [3:0] mon;
        logic [5:0] date;
        logic [6:0] yr;
        logic [4:0] mdays;
    } t_s2;

    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;

    logic [STATUS_W-1:0] r_status, n_status;
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic [SECOND_W-1:0] r_second;

    assign busy = 1'b0;

    // Stage 1: mask flags, check digits, convert BCD
    always_comb begin
        logic [7:0] sec_m, min_m, date_m, mon_m, hr_m;
        logic       mode12;
        logic [6:0] hr_b, date_b, mon_b;
        sec_m  = i_seconds_raw & SEC_MASK;
        min_m  = i_minutes_raw & SEC_MASK;
        date_m = i_date_raw & DATE_MASK;
        mon_m  = i_month_raw & MONTH_MASK;
        mode12 = i_hours_raw[H12_BIT];
        hr_m   = i_hours_raw & (mode12 ? H12_MASK : H24_MASK);
        hr_b   = bcd_value(hr_m);
        date_b = bcd_value(date_m);
        mon_b  = bcd_value(mon_m);

        n_s1.digits_ok = digits_ok(sec_m) && digits_ok(min_m) && digits_ok(date_m)
                       && digits_ok(mon_m) && digits_ok(i_year_raw) && digits_ok(hr_m);
        n_s1.mode12 = mode12;
        n_s1.pm     = i_hours_raw[PM_BIT];
        n_s1.sec    = bcd_value(sec_m);
        n_s1.min    = bcd_value(min_m);
        n_s1.hour   = hr_b[5:0];
        n_s1.date   = date_b[5:0];
        n_s1.mon    = mon_b[4:0];
        n_s1.yr     = bcd_value(i_year_raw);
    end

    // Stage 2: range checks, 24-hour form, month length
    always_comb begin
        logic       hour_bad;
        logic [4:0] hour24;
        hour_bad = 1'b0;
        hour24   = r_s1.hour[4:0];
        if (r_s1.mode12) begin
            hour_bad = (r_s1.hour == 6'd0) || (r_s1.hour > 6'd12);
            hour24   = ((r_s1.hour == 6'd12) ? 5'd0 : r_s1.hour[4:0])
                     + (r_s1.pm ? 5'd12 : 5'd0);
        end else begin
            hour_bad = r_s1.hour > 6'd23;
        end

        n_s2.range_err = !r_s1.digits_ok || hour_bad || (r_s1.sec > 7'd59)
                       || (r_s1.min > 7'd59) || (r_s1.mon == 5'd0) || (r_s1.mon > 5'd12);
        n_s2.hour  = hour24;
        n_s2.sec   = r_s1.sec[5:0];
        n_s2.min   = r_s1.min[5:0];
        n_s2.mon   = r_s1.mon[3:0];
        n_s2.date  = r_s1.date;
        n_s2.yr    = r_s1.yr;
        // 2000..2099: leap exactly when the two-digit year is a multiple of four
        n_s2.mdays = month_days(r_s1.mon[3:0], r_s1.yr[1:0] == 2'b00);
    end

    // Stage 3: day check and final status
    always_comb begin
        if (r_s2.range_err) begin
            n_status = ST_RANGE;
        end else if (r_s2.date == 6'd0 || r_s2.date > {1'b0, r_s2.mdays}) begin
            n_status = ST_DAY;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_status <= n_status;
        if (n_status == ST_OK) begin
            r_year   <= YEAR_BASE + {5'b00000, r_s2.yr};
            r_month  <= r_s2.mon;
            r_day    <= r_s2.date[4:0];
            r_hour   <= r_s2.hour;
            r_minute <= r_s2.min;
            r_second <= r_s2.sec;
        end else begin
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end
    end

    assign o_valid  = r_v3;
    assign o_status = r_status;
    assign o_year   = r_year;
    assign o_month  = r_month;
    assign o_day    = r_day;
    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted snapshot did not produce a result after three cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("result without a matching snapshot");

    a_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_year == '0 && o_month == '0 && o_day == '0
            && o_hour == '0 && o_minute == '0 && o_second == '0))
        else $error("fields not cleared on error status");

    a_ok_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_month != '0 && o_month <= 4'd12
            && o_day != '0 && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("ok status with out-of-range field");
`endif

endmodule

`default_nettype wire

// ----- verif/bcd_rtc_time_decode_validate_top_tb.sv -----
// Self-checking testbench for the BCD clock register decoder: directed table, then random snapshots.
// Depends on bcd_rtc_pkg and bcd_rtc_time_decode_validate_top; results are checked in order.
`timescale 1ns / 1ps

module bcd_rtc_time_decode_validate_top_tb;
    import bcd_rtc_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] mins;
        logic [7:0] hrs;
        logic [7:0] date;
        logic [7:0] mon;
        logic [7:0] yr;
    } t_snapshot;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_datetime;

    typedef struct {
        t_snapshot raw;
        bit        typed;
        t_datetime want;
    } t_vector;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [7:0]          i_seconds_raw;
    logic [7:0]          i_minutes_raw;
    logic [7:0]          i_hours_raw;
    logic [7:0]          i_date_raw;
    logic [7:0]          i_month_raw;
    logic [7:0]          i_year_raw;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [YEAR_W-1:0]   o_year;
    logic [MONTH_W-1:0]  o_month;
    logic [DAY_W-1:0]    o_day;
    logic [HOUR_W-1:0]   o_hour;
    logic [MINUTE_W-1:0] o_minute;
    logic [SECOND_W-1:0] o_second;

    // driven but not yet accepted, then accepted and awaiting their result
    t_datetime staged_dt[$];
    t_datetime awaited_dt[$];
    t_vector   directed_rows[$];
    int        mismatches;
    int        stall_cycles;

    bcd_rtc_time_decode_validate_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_seconds_raw (i_seconds_raw),
        .i_minutes_raw (i_minutes_raw),
        .i_hours_raw   (i_hours_raw),
        .i_date_raw    (i_date_raw),
        .i_month_raw   (i_month_raw),
        .i_year_raw    (i_year_raw),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_year        (o_year),
        .o_month       (o_month),
        .o_day         (o_day),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_bcd(logic [7:0] v);
        return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
    endfunction

    function automatic int bcd_to_int(logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [7:0] int_to_bcd(int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic t_datetime stamp(int y, int mo, int d, int h, int mi, int s);
        t_datetime r;
        r.status = ST_OK;
        r.year   = YEAR_W'(y);
        r.month  = MONTH_W'(mo);
        r.day    = DAY_W'(d);
        r.hour   = HOUR_W'(h);
        r.minute = MINUTE_W'(mi);
        r.second = SECOND_W'(s);
        return r;
    endfunction

    function automatic t_datetime rejected(logic [STATUS_W-1:0] st);
        t_datetime r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic void add_row(t_snapshot raw, bit typed, t_datetime want);
        t_vector v;
        v.raw   = raw;
        v.typed = typed;
        v.want  = want;
        directed_rows.push_back(v);
    endfunction

    // Decode of one register snapshot into status and binary date/time
    function automatic t_datetime decode_snapshot(t_snapshot s);
        logic [7:0] sec_f, min_f, hr_f, date_f, mon_f;
        int         hour, sv, mv, mo, yv, dv, mlen;
        bit         bad;
        sec_f  = s.sec & SEC_MASK;
        min_f  = s.mins & SEC_MASK;
        date_f = s.date & DATE_MASK;
        mon_f  = s.mon & MONTH_MASK;
        hour   = 0;
        bad    = !is_bcd(sec_f) || !is_bcd(min_f) || !is_bcd(date_f) ||
                 !is_bcd(mon_f) || !is_bcd(s.yr);
        if (!bad) begin
            if (s.hrs[H12_BIT]) begin
                hr_f = s.hrs & H12_MASK;
                if (!is_bcd(hr_f)) begin
                    bad = 1'b1;
                end else begin
                    hour = bcd_to_int(hr_f);
                    if (hour < 1 || hour > 12)
                        bad = 1'b1;
                    else
                        hour = (hour % 12) + (s.hrs[PM_BIT] ? 12 : 0);
                end
            end else begin
                hr_f = s.hrs & H24_MASK;
                if (!is_bcd(hr_f)) begin
                    bad = 1'b1;
                end else begin
                    hour = bcd_to_int(hr_f);
                    if (hour > 23)
                        bad = 1'b1;
                end
            end
        end
        if (bad)
            return rejected(ST_RANGE);

        sv = bcd_to_int(sec_f);
        mv = bcd_to_int(min_f);
        mo = bcd_to_int(mon_f);
        dv = bcd_to_int(date_f);
        yv = int'(YEAR_BASE) + bcd_to_int(s.yr);
        if (sv > 59 || mv > 59 || mo < 1 || mo > 12)
            return rejected(ST_RANGE);

        case (mo)
            2:            mlen = ((yv % 4 == 0 && yv % 100 != 0) || yv % 400 == 0) ? 29 : 28;
            4, 6, 9, 11:  mlen = 30;
            default:      mlen = 31;
        endcase
        if (dv < 1 || dv > mlen)
            return rejected(ST_DAY);
        return stamp(yv, mo, dv, hour, mv, sv);
    endfunction

    // Mostly plausible register contents with random flag bits, plus some plain noise
    function automatic t_snapshot random_snapshot();
        t_snapshot s;
        int        v;
        logic [47:0] flat;
        if ($urandom_range(0, 9) < 3) begin
            flat = 48'({$urandom, $urandom});
            return t_snapshot'(flat);
        end
        v = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 79) : $urandom_range(0, 59);
        s.sec = int_to_bcd(v) | {$urandom_range(0, 1) == 1, 7'd0};
        v = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 79) : $urandom_range(0, 59);
        s.mins = int_to_bcd(v) | {$urandom_range(0, 1) == 1, 7'd0};
        if ($urandom_range(0, 1) == 1) begin
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19) : $urandom_range(1, 12);
            s.hrs = int_to_bcd(v) | 8'h40 | {2'b00, $urandom_range(0, 1) == 1, 5'd0};
        end else begin
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 39) : $urandom_range(0, 23);
            s.hrs = int_to_bcd(v);
        end
        s.hrs[7] = 1'($urandom_range(0, 1));
        v = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 19) : $urandom_range(1, 12);
        s.mon = int_to_bcd(v) | {3'($urandom), 5'd0};
        v = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 39) : $urandom_range(1, 31);
        s.date = int_to_bcd(v) | {2'($urandom), 6'd0};
        s.yr = int_to_bcd($urandom_range(0, 99));
        // end of February, leap or not
        if ($urandom_range(0, 7) == 0) begin
            s.mon  = 8'h02;
            s.date = int_to_bcd($urandom_range(28, 30));
        end
        // one nibble pushed out of the decimal range
        if ($urandom_range(0, 9) == 0) begin
            flat = s;
            v = $urandom_range(0, 11);
            flat[v*4 +: 4] = 4'($urandom_range(10, 15));
            s = t_snapshot'(flat);
        end
        return s;
    endfunction

    task automatic report_error(string msg);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_snapshot(t_snapshot s, t_datetime want);
        staged_dt.push_back(want);
        start         <= 1'b1;
        i_seconds_raw <= s.sec;
        i_minutes_raw <= s.mins;
        i_hours_raw   <= s.hrs;
        i_date_raw    <= s.date;
        i_month_raw   <= s.mon;
        i_year_raw    <= s.yr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // idle cycles carry junk on the data ports
    task automatic pause_sender(int n);
        repeat (n) begin
            start         <= 1'b0;
            i_seconds_raw <= 8'($urandom);
            i_minutes_raw <= 8'($urandom);
            i_hours_raw   <= 8'($urandom);
            i_date_raw    <= 8'($urandom);
            i_month_raw   <= 8'($urandom);
            i_year_raw    <= 8'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (staged_dt.size() != 0 || awaited_dt.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_datetime got, want;
        if (i_rst_n) begin
            if (start && !busy && staged_dt.size() != 0)
                awaited_dt.push_back(staged_dt.pop_front());
            if (o_valid) begin
                got = {o_status, o_year, o_month, o_day, o_hour, o_minute, o_second};
                if (awaited_dt.size() == 0) begin
                    report_error("result with no transaction outstanding");
                end else begin
                    want = awaited_dt.pop_front();
                    if (got !== want)
                        report_error($sformatf({"mismatch exp st=%0d %0d-%0d-%0d %0d:%0d:%0d",
                            " got st=%0d %0d-%0d-%0d %0d:%0d:%0d"},
                            want.status, want.year, want.month, want.day,
                            want.hour, want.minute, want.second,
                            got.status, got.year, got.month, got.day,
                            got.hour, got.minute, got.second));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_snapshot s;
        int        burst;
        mismatches    = 0;
        stall_cycles  = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_seconds_raw = 8'h00;
        i_minutes_raw = 8'h00;
        i_hours_raw   = 8'h00;
        i_date_raw    = 8'h00;
        i_month_raw   = 8'h00;
        i_year_raw    = 8'h00;

        //       sec    min    hrs    date   month  year
        add_row({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1, stamp(2000, 1, 1, 0, 0, 0));
        add_row({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99}, 1,
                stamp(2099, 12, 31, 23, 59, 59));
        add_row({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1, rejected(ST_RANGE));
        // flag bits and century bit set everywhere they are ignored
        add_row({8'hD9, 8'h80, 8'hA3, 8'hC1, 8'hE1, 8'h24}, 0, '0);
        // twelve-hour mode: midnight, noon, 1 PM, 11 PM
        add_row({8'h30, 8'h15, 8'h52, 8'h15, 8'h06, 8'h25}, 0, '0);
        add_row({8'h30, 8'h15, 8'h72, 8'h15, 8'h06, 8'h25}, 0, '0);
        add_row({8'h00, 8'h00, 8'h61, 8'h15, 8'h06, 8'h25}, 0, '0);
        add_row({8'h59, 8'h59, 8'hF1, 8'h15, 8'h06, 8'h25}, 0, '0);
        add_row({8'h00, 8'h00, 8'h40, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h00, 8'h53, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h00, 8'h4A, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h00, 8'h1A, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h00}, 1, rejected(ST_RANGE));
        add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00}, 1, rejected(ST_RANGE));
        // calendar day: leap years, month ends, day zero, day 32
        add_row({8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24}, 0, '0);
        add_row({8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h23}, 1, rejected(ST_DAY));
        add_row({8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00}, 0, '0);
        add_row({8'h00, 8'h00, 8'h00, 8'h30, 8'h02, 8'h24}, 1, rejected(ST_DAY));
        add_row({8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h25}, 1, rejected(ST_DAY));
        add_row({8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h25}, 1, rejected(ST_DAY));
        add_row({8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h25}, 1, rejected(ST_DAY));
        add_row({8'h00, 8'h00, 8'h00, 8'h3A, 8'h01, 8'h9A}, 1, rejected(ST_RANGE));
        // range error wins over a bad day
        add_row({8'h7A, 8'h00, 8'h00, 8'h00, 8'h02, 8'h23}, 1, rejected(ST_RANGE));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 3));
            send_snapshot(directed_rows[k].raw,
                          directed_rows[k].typed ? directed_rows[k].want
                                                 : decode_snapshot(directed_rows[k].raw));
        end
        wait_results();

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                wait_results();
            if (burst == 0) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 6));
            end
            s = random_snapshot();
            send_snapshot(s, decode_snapshot(s));
            burst--;
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_dt.size() != 0 || staged_dt.size() != 0)
            report_error("transactions left without a result");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
